/* hdl/nearest_request_disk_scheduler_unit_assert.svh */
// Assertion macros for the nearest request disk scheduler.
`ifndef NEAREST_REQUEST_DISK_SCHEDULER_UNIT_ASSERT_SVH
`define NEAREST_REQUEST_DISK_SCHEDULER_UNIT_ASSERT_SVH
// Property that holds whenever reset is low.
`define NRDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that holds in every cycle, reset included.
`define NRDS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hdl/nrds_pkg.sv */
// ----------------------------------------------------------------------------
// nrds_pkg
// Types and codes shared by the disk scheduler files.
// ----------------------------------------------------------------------------
`default_nettype none
package nrds_pkg;
  localparam int SECTOR_BITS = 48;
  localparam int COUNT_BITS  = 16;
  localparam int TAG_WIDTH   = 8;
  localparam int STATUS_BITS = 2;
  localparam int PEND_BITS   = 7;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] sec;
    logic [COUNT_BITS-1:0]  cnt;
    logic [TAG_WIDTH-1:0]   tag;
  } entry_t;
endpackage
`default_nettype wire

/* hdl/nrds_if.sv */
// ----------------------------------------------------------------------------
// nrds_cmd_if / nrds_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface nrds_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  request_tag;
  logic [47:0] start_sector;
  logic [15:0] sector_count;
  modport source (output valid, command, request_tag, start_sector, sector_count,
                  input ready);
  modport sink (input valid, command, request_tag, start_sector, sector_count,
                output ready);
endinterface

interface nrds_res_if;
  logic        valid;
  logic        ready;
  logic        issued;
  logic [7:0]  issued_tag;
  logic [47:0] issued_sector;
  logic [15:0] issued_count;
  logic [1:0]  status;
  logic [6:0]  pending;
  modport source (output valid, issued, issued_tag, issued_sector, issued_count,
                  status, pending, input ready);
  modport sink (input valid, issued, issued_tag, issued_sector, issued_count,
                status, pending, output ready);
endinterface
`default_nettype wire

/* hdl/nrds_ram.sv */
// ----------------------------------------------------------------------------
// nrds_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module nrds_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/nearest_request_disk_scheduler_unit.sv */
// One item is in work at a time: a new command is accepted only after the result of the
// last one is taken. Add and remove walk the sorted store or search it by tag, and add,
// dispatch and remove then shift one entry a cycle through the single RAM port of a store.
// Reset (synchronous, rst high) clears head and fill counts; store contents stay.
// ----------------------------------------------------------------------------
// nearest_request_disk_scheduler_unit
// Shortest seek time first scheduler over two sorted request stores.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_request_disk_scheduler_unit #(
  parameter int STORE_DEPTH = 32,
  parameter int TAG_BITS    = 8
) (
  input wire logic clk,
  input wire logic rst,
  nrds_cmd_if.sink   cmd,
  nrds_res_if.source res
);
  import nrds_pkg::*;
  `include "nearest_request_disk_scheduler_unit_assert.svh"

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int EW = SECTOR_BITS + COUNT_BITS + TAG_WIDTH;
  localparam logic [SECTOR_BITS-1:0] POS_MAX = '1;

  state_t state, state_next;

  logic [SECTOR_BITS-1:0] head;
  logic [FW-1:0] fill [2];
  cmd_t cur_cmd;
  entry_t cur;
  logic side;          // 0 lower, 1 upper
  logic [FW-1:0] idx;  // walk position
  logic [FW-1:0] at;   // delete position
  logic rd_wait;       // first cycle of a walk or a shift
  entry_t front [2];
  logic [SECTOR_BITS-1:0] dlr, dur;
  logic [1:0] pick_step;

  // RAM ports
  logic          we [2];
  logic [AW-1:0] addr [2];
  entry_t        wdata [2];
  logic [EW-1:0] rdata [2];

  for (genvar g = 0; g < 2; g++) begin : g_store
    nrds_ram #(.WIDTH(EW), .DEPTH(STORE_DEPTH)) u_ram (
      .clk(clk), .we(we[g]), .addr(addr[g]), .wdata(wdata[g]), .rdata(rdata[g])
    );
  end

  entry_t rd;
  logic [TAG_WIDTH-1:0] tmask;
  assign rd = side ? entry_t'(rdata[1]) : entry_t'(rdata[0]);
  assign tmask = TAG_WIDTH'((17'd1 << TAG_BITS) - 17'd1);

  // Result register
  logic        r_issued;
  entry_t      r_ent;
  status_t     r_status;

  // Decisions shared by the next-state logic and the datapath.
  logic in_side, add_full, both_empty, scan_hit, shift_last, pick_upper;
  assign in_side = !(cmd.start_sector < head);
  assign add_full = (fill[in_side] == FW'(STORE_DEPTH));
  assign both_empty = (fill[0] == '0) && (fill[1] == '0);
  assign scan_hit = !rd_wait && ((cur_cmd == CMD_ADD) ?
                    (side ? (cur.sec < rd.sec) : (cur.sec > rd.sec)) : (rd.tag == cur.tag));
  assign shift_last = (cur_cmd == CMD_ADD) ? (idx == fill[side]) : (idx == at);

  // Distance compare on the registered front entries.
  logic [SECTOR_BITS-1:0] dl, du;
  assign dl = (front[0].sec < head) ? head - front[0].sec : front[0].sec - head;
  assign du = (front[1].sec < head) ? head - front[1].sec : front[1].sec - head;
  assign pick_upper = (fill[0] == '0) ? 1'b1 : (fill[1] == '0) ? 1'b0 : !(dlr < dur);

  logic [SECTOR_BITS:0] end_sum;
  logic [SECTOR_BITS-1:0] head_end;
  assign end_sum = {1'b0, r_ent.sec} + {{(SECTOR_BITS-COUNT_BITS+1){1'b0}}, r_ent.cnt};
  assign head_end = end_sum[SECTOR_BITS] ? POS_MAX : end_sum[SECTOR_BITS-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.valid) begin
        case (cmd_t'(cmd.command))
          CMD_ADD:      state_next = add_full ? S_DONE : S_SCAN;
          CMD_DISPATCH: state_next = both_empty ? S_DONE : S_PICK;
          CMD_REMOVE:   state_next = S_SCAN;
          default:      state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (scan_hit) state_next = S_SHIFT;
        else if (idx == fill[side]) begin
          if (cur_cmd == CMD_ADD) state_next = S_SHIFT;
          else if (side) state_next = S_DONE;
        end
      end
      S_SHIFT: if (shift_last) state_next = S_DONE;
      S_PICK:  if (pick_step == 2'd3) state_next = S_SHIFT;
      S_DONE:  if (res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // An insert walks upward writing the new entry, then each old entry one place up.
  // A delete walks downward from the last entry, each write landing one place below.
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      we[g] = 1'b0;
      addr[g] = (state == S_PICK) ? '0 : idx[AW-1:0];
      wdata[g] = rd_wait ? cur : rd;
    end
    if (state == S_SHIFT) begin
      we[side] = (cur_cmd == CMD_ADD) ? 1'b1 : !rd_wait;
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = (state == S_DONE);
  assign res.issued = r_issued;
  assign res.issued_tag = r_issued ? r_ent.tag : '0;
  assign res.issued_sector = r_issued ? r_ent.sec : '0;
  assign res.issued_count = r_issued ? r_ent.cnt : '0;
  assign res.status = r_status;
  assign res.pending = PEND_BITS'(fill[0]) + PEND_BITS'(fill[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      fill[0] <= '0;
      fill[1] <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cur_cmd <= cmd_t'(cmd.command);
            cur.sec <= cmd.start_sector;
            cur.cnt <= cmd.sector_count;
            cur.tag <= cmd.request_tag & tmask;
            side <= (cmd_t'(cmd.command) == CMD_REMOVE) ? 1'b0 : in_side;
            idx <= '0;
            rd_wait <= 1'b1;
            r_issued <= 1'b0;
            pick_step <= '0;
            case (cmd_t'(cmd.command))
              CMD_ADD:      r_status <= add_full ? ST_FULL : ST_OK;
              CMD_DISPATCH: r_status <= both_empty ? ST_EMPTY : ST_OK;
              default:      r_status <= ST_OK;
            endcase
          end
        end
        S_SCAN: begin
          // rd holds entry idx-1 once the first read has landed.
          if (scan_hit) begin
            rd_wait <= 1'b1;
            if (cur_cmd == CMD_ADD) begin
              idx <= idx - 1'b1;
            end else begin
              at <= idx - 1'b1;
              idx <= fill[side] - 1'b1;
            end
          end else if (idx == fill[side]) begin
            rd_wait <= 1'b1;
            if (cur_cmd != CMD_ADD) begin
              if (!side) begin
                side <= 1'b1;
                idx <= '0;
              end else r_status <= ST_NOTFOUND;
            end
          end else begin
            idx <= idx + 1'b1;
            rd_wait <= 1'b0;
          end
        end
        S_SHIFT: begin
          rd_wait <= 1'b0;
          if (rd_wait && cur_cmd == CMD_DISPATCH) head <= head_end;
          if (shift_last) begin
            fill[side] <= (cur_cmd == CMD_ADD) ? fill[side] + 1'b1 : fill[side] - 1'b1;
          end else if (cur_cmd == CMD_ADD) begin
            idx <= idx + 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_PICK: begin
          pick_step <= pick_step + 1'b1;
          if (pick_step == 2'd1) begin
            front[0] <= entry_t'(rdata[0]);
            front[1] <= entry_t'(rdata[1]);
          end
          if (pick_step == 2'd2) begin
            dlr <= dl;
            dur <= du;
          end
          if (pick_step == 2'd3) begin
            side <= pick_upper;
            r_issued <= 1'b1;
            r_ent <= pick_upper ? front[1] : front[0];
            at <= '0;
            idx <= fill[pick_upper] - 1'b1;
            rd_wait <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `NRDS_ASSERT(a_ready_idle, cmd.ready |-> !res.valid, "ready while result pending")
  `NRDS_ASSERT(a_fill_lo, fill[0] <= FW'(STORE_DEPTH), "lower fill overflow")
  `NRDS_ASSERT(a_fill_hi, fill[1] <= FW'(STORE_DEPTH), "upper fill overflow")
  `NRDS_ASSERT_ALWAYS(a_rst, rst |=> (state == S_IDLE), "not idle after reset")
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disk scheduler testbench
// Drives add, dispatch and remove items through the command channel, predicts
// each result with a model of the two sorted stores and the head, and checks
// every result item field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import nrds_pkg::*;

  localparam int DEPTH   = 32;
  localparam logic [47:0] POS_LIMIT = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  tag;
    logic [47:0] sector;
    logic [15:0] count;
  } request_t;

  typedef struct packed {
    logic        issued;
    logic [7:0]  tag;
    logic [47:0] sector;
    logic [15:0] count;
    logic [1:0]  status;
    logic [6:0]  pending;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  nrds_cmd_if cmd_ch ();
  nrds_res_if res_ch ();

  nearest_request_disk_scheduler_unit uut (
    .clk(clk), .rst(rst), .cmd(cmd_ch.sink), .res(res_ch.source)
  );

  // Model of the scheduler state.
  logic [47:0] head_pos;
  entry_t      low_q[$];
  entry_t      up_q[$];

  request_t pending_items[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  function automatic logic [47:0] gap(logic [47:0] a, logic [47:0] b);
    return (a < b) ? b - a : a - b;
  endfunction

  function automatic outcome_t schedule_item(request_t r);
    outcome_t o;
    entry_t   e;
    int       at;
    logic [48:0] fin;
    bit       hit;
    bit       use_low;
    o = '0;
    o.status = ST_OK;
    case (r.command)
      CMD_ADD: begin
        e.sec = r.sector;
        e.cnt = r.count;
        e.tag = r.tag;
        if (r.sector < head_pos) begin
          if (low_q.size() >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            at = 0;
            while (at < low_q.size() && !(r.sector > low_q[at].sec)) at++;
            low_q.insert(at, e);
          end
        end else begin
          if (up_q.size() >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            at = 0;
            while (at < up_q.size() && !(r.sector < up_q[at].sec)) at++;
            up_q.insert(at, e);
          end
        end
      end
      CMD_DISPATCH: begin
        if (low_q.size() == 0 && up_q.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          if (low_q.size() == 0) use_low = 0;
          else if (up_q.size() == 0) use_low = 1;
          else use_low = gap(low_q[0].sec, head_pos) < gap(up_q[0].sec, head_pos);
          e = use_low ? low_q.pop_front() : up_q.pop_front();
          o.issued = 1'b1;
          o.tag = e.tag;
          o.sector = e.sec;
          o.count = e.cnt;
          fin = {1'b0, e.sec} + {33'd0, e.cnt};
          head_pos = fin[48] ? POS_LIMIT : fin[47:0];
        end
      end
      CMD_REMOVE: begin
        hit = 0;
        for (int i = 0; i < low_q.size() && !hit; i++) begin
          if (low_q[i].tag == r.tag) begin
            low_q.delete(i);
            hit = 1;
          end
        end
        for (int i = 0; i < up_q.size() && !hit; i++) begin
          if (up_q[i].tag == r.tag) begin
            up_q.delete(i);
            hit = 1;
          end
        end
        if (!hit) o.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    o.pending = 7'(low_q.size() + up_q.size());
    return o;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (cmd_ch.valid) void'(pending_items.pop_front());
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= pending_items[0].command;
        cmd_ch.request_tag  <= pending_items[0].tag;
        cmd_ch.start_sector <= pending_items[0].sector;
        cmd_ch.sector_count <= pending_items[0].count;
        expected_outcomes.push_back(schedule_item(pending_items[0]));
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.issued, res_ch.issued_tag, res_ch.issued_sector,
               res_ch.issued_count, res_ch.status, res_ch.pending};
        if (expected_outcomes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %h", got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [47:0] pick_sector();
    case ($urandom_range(5))
      0: return 48'd0;
      1: return POS_LIMIT - 48'($urandom_range(70000));
      2: return 48'({$urandom, $urandom});
      default: return head_pos + 48'($urandom_range(4000)) - 48'd2000;
    endcase
  endfunction

  task automatic queue_item(logic [1:0] c, logic [7:0] t, logic [47:0] s, logic [15:0] n);
    request_t r;
    r.command = c;
    r.tag = t;
    r.sector = s;
    r.count = n;
    pending_items.push_back(r);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
  endtask

  task automatic random_burst(int n);
    int k;
    int roll;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 45)
        queue_item(CMD_ADD, 8'($urandom_range(255)), pick_sector(),
                   16'($urandom_range(65535)));
      else if (roll < 80)
        queue_item(CMD_DISPATCH, 8'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
      else if (roll < 95)
        queue_item(CMD_REMOVE, 8'($urandom_range(255)), 48'({$urandom, $urandom}),
                   16'($urandom));
      else
        queue_item(CMD_NONE, 8'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
    end
  endtask

  initial begin
    int k;
    head_pos = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_NONE;
    cmd_ch.request_tag = '0;
    cmd_ch.start_sector = '0;
    cmd_ch.sector_count = '0;
    res_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dispatch, unused command, missing tag, extremes, saturation.
    send_idle_pct = 20;
    recv_idle_pct = 51;
    queue_item(CMD_DISPATCH, 8'd0, '0, '0);
    queue_item(CMD_NONE, 8'hFF, POS_LIMIT, 16'hFFFF);
    queue_item(CMD_REMOVE, 8'h55, '0, '0);
    queue_item(CMD_ADD, 8'hFF, POS_LIMIT - 48'd5, 16'hFFFF);
    queue_item(CMD_ADD, 8'h01, 48'd100, 16'd10);
    queue_item(CMD_ADD, 8'h02, 48'd100, 16'd0);
    queue_item(CMD_DISPATCH, '0, '0, '0);
    queue_item(CMD_ADD, 8'h03, 48'd50, 16'd1);
    queue_item(CMD_ADD, 8'h03, 48'd170, 16'd1);
    queue_item(CMD_REMOVE, 8'h03, '0, '0);
    queue_item(CMD_DISPATCH, '0, '0, '0);
    queue_item(CMD_DISPATCH, '0, '0, '0);
    queue_item(CMD_DISPATCH, '0, '0, '0);
    queue_item(CMD_ADD, 8'h00, 48'd0, 16'd0);
    queue_item(CMD_DISPATCH, '0, '0, '0);
    queue_item(CMD_DISPATCH, '0, '0, '0);
    drain();
    // Fill the upper store past its depth so the full status appears.
    for (k = 0; k < DEPTH + 2; k++)
      queue_item(CMD_ADD, k[7:0], 48'd1000 + 48'(k), 16'd3);
    for (k = 0; k < DEPTH + 1; k++)
      queue_item(CMD_DISPATCH, '0, '0, '0);
    drain();

    random_burst(220);
    drain();
    send_idle_pct = 51;
    recv_idle_pct = 20;
    random_burst(220);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(220);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule
